// ===== rtl/ebml_hdr_pkg.sv =====
// ----------------------------------------------------------------------------
// EBML element header parser package
// Shared constants, codes and the result record of the header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ebml_hdr_pkg;

    localparam int MAX_ID_BYTES = 4;
    localparam int POS_W        = 48;
    localparam int ACC_W        = 56;
    localparam int ID_W         = 32;
    localparam int OUT_TDATA_W  = 144;
    localparam int OUT_TUSER_W  = 3;

    typedef enum logic [2:0] {
        PH_ID_LEAD   = 3'd0,
        PH_ID_MORE   = 3'd1,
        PH_SIZE_LEAD = 3'd2,
        PH_SIZE_MORE = 3'd3,
        PH_SKIP      = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ERR_OK          = 3'd0,
        ERR_NO_MARKER   = 3'd1,
        ERR_ID_TOO_LONG = 3'd2,
        ERR_TRUNCATED   = 3'd3,
        ERR_OVERRUN     = 3'd4
    } err_code_t;

    typedef struct packed {
        logic [ID_W-1:0]  element_id;
        logic [2:0]       id_length;
        logic [ACC_W-1:0] content_size;
        logic [3:0]       size_length;
        logic             unknown_size;
        logic [POS_W-1:0] content_offset;
        err_code_t        error_code;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/ebml_hdr_in_stage.sv =====
// ----------------------------------------------------------------------------
// EBML header parser input stage
// Registers one incoming stream byte and its end marker.
// ----------------------------------------------------------------------------
`default_nettype none

module ebml_hdr_in_stage (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // data_byte
    input  wire logic       s_tlast,   // end_of_data
    input  wire logic       take,
    output logic            byte_valid,
    output logic [7:0]      data_byte,
    output logic            end_of_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       end_reg;

    assign s_tready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tready)
        begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            data_reg <= s_tdata;
            end_reg  <= s_tlast;
        end
    end

    assign byte_valid  = valid_reg;
    assign data_byte   = data_reg;
    assign end_of_data = end_reg;

endmodule

`default_nettype wire

// ===== rtl/ebml_hdr_parser.sv =====
// ----------------------------------------------------------------------------
// EBML header parser core
// Decodes ID and size integers a byte a cycle on advance, skips content.
// ----------------------------------------------------------------------------
`default_nettype none

module ebml_hdr_parser (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_data,
    input  wire logic       advance,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_of_data,
    output logic            res_valid,
    output ebml_hdr_pkg::result_t res
);

    ebml_hdr_pkg::phase_t phase_reg;
    ebml_hdr_pkg::phase_t phase_next;

    logic [ebml_hdr_pkg::ACC_W-1:0] acc_reg;
    logic [ebml_hdr_pkg::ACC_W-1:0] acc_next;
    logic [2:0]                     bl_reg;
    logic [2:0]                     bl_next;
    logic [ebml_hdr_pkg::ID_W-1:0]  held_id_reg;
    logic [ebml_hdr_pkg::ID_W-1:0]  held_id_next;
    logic [2:0]                     id_len_reg;
    logic [2:0]                     id_len_next;
    logic [3:0]                     size_len_reg;
    logic [3:0]                     size_len_next;
    logic                           ones_reg;
    logic                           ones_next;
    logic [ebml_hdr_pkg::ACC_W-1:0] skip_rem_reg;
    logic [ebml_hdr_pkg::ACC_W-1:0] skip_rem_next;
    logic [ebml_hdr_pkg::POS_W-1:0] pos_reg;
    logic [ebml_hdr_pkg::POS_W-1:0] pos_next;
    logic                           halted_reg;
    logic                           halted_next;
    logic                           skip_cfg_reg;
    logic                           skip_cfg_next;

    logic                           work;
    logic [3:0]                     lead_len;
    logic [7:0]                     size_mask;
    logic                           bl_last;
    logic                           done;
    logic                           fail;
    ebml_hdr_pkg::err_code_t        fail_code;
    logic                           skip_end;
    logic                           known_nonzero;
    logic                           done_overrun;

    assign work      = advance && !halted_reg;
    assign size_mask = 8'hFF >> lead_len;
    assign bl_last   = (bl_reg == 3'd1);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        lead_len = 4'd9;
        for (int i = 0; i < 8; i++)
        begin
            if (data_byte[i])
            begin
                lead_len = 4'(8 - i);
            end
        end
    end

    always_comb
    begin
        skip_cfg_next = skip_cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            skip_cfg_next = cfg_data;
        end
    end

    // Datapath next values and the completion and error decisions.
    always_comb
    begin
        acc_next      = acc_reg;
        bl_next       = bl_reg;
        held_id_next  = held_id_reg;
        id_len_next   = id_len_reg;
        size_len_next = size_len_reg;
        ones_next     = ones_reg;
        skip_rem_next = skip_rem_reg;
        pos_next      = pos_reg;
        done          = 1'b0;
        fail          = 1'b0;
        fail_code     = ebml_hdr_pkg::ERR_OK;
        skip_end      = 1'b0;
        if (work)
        begin
            pos_next = pos_reg + 1'b1;
            case (phase_reg)
                ebml_hdr_pkg::PH_ID_LEAD:
                begin
                    if (data_byte == 8'h00)
                    begin
                        fail      = 1'b1;
                        fail_code = ebml_hdr_pkg::ERR_NO_MARKER;
                    end
                    else if (lead_len > 4'(ebml_hdr_pkg::MAX_ID_BYTES))
                    begin
                        fail      = 1'b1;
                        fail_code = ebml_hdr_pkg::ERR_ID_TOO_LONG;
                    end
                    else
                    begin
                        acc_next    = {{(ebml_hdr_pkg::ACC_W-8){1'b0}}, data_byte};
                        id_len_next = lead_len[2:0];
                        if (lead_len == 4'd1)
                        begin
                            held_id_next = {{(ebml_hdr_pkg::ID_W-8){1'b0}}, data_byte};
                        end
                        else
                        begin
                            bl_next = lead_len[2:0] - 3'd1;
                        end
                    end
                end
                ebml_hdr_pkg::PH_ID_MORE:
                begin
                    acc_next = {acc_reg[ebml_hdr_pkg::ACC_W-9:0], data_byte};
                    bl_next  = bl_reg - 3'd1;
                    if (bl_last)
                    begin
                        held_id_next = acc_next[ebml_hdr_pkg::ID_W-1:0];
                    end
                end
                ebml_hdr_pkg::PH_SIZE_LEAD:
                begin
                    if (data_byte == 8'h00)
                    begin
                        fail      = 1'b1;
                        fail_code = ebml_hdr_pkg::ERR_NO_MARKER;
                    end
                    else
                    begin
                        acc_next      = {{(ebml_hdr_pkg::ACC_W-8){1'b0}},
                                         data_byte & size_mask};
                        ones_next     = ((data_byte & size_mask) == size_mask);
                        size_len_next = lead_len;
                        if (lead_len == 4'd1)
                        begin
                            done = 1'b1;
                        end
                        else
                        begin
                            bl_next = lead_len[2:0] - 3'd1;
                        end
                    end
                end
                ebml_hdr_pkg::PH_SIZE_MORE:
                begin
                    acc_next = {acc_reg[ebml_hdr_pkg::ACC_W-9:0], data_byte};
                    if (data_byte != 8'hFF)
                    begin
                        ones_next = 1'b0;
                    end
                    bl_next = bl_reg - 3'd1;
                    if (bl_last)
                    begin
                        done = 1'b1;
                    end
                end
                ebml_hdr_pkg::PH_SKIP:
                begin
                    if (skip_rem_reg == {{(ebml_hdr_pkg::ACC_W-1){1'b0}}, 1'b1})
                    begin
                        skip_rem_next = '0;
                        skip_end      = 1'b1;
                    end
                    else
                    begin
                        skip_rem_next = skip_rem_reg - 1'b1;
                        if (end_of_data)
                        begin
                            fail      = 1'b1;
                            fail_code = ebml_hdr_pkg::ERR_OVERRUN;
                        end
                    end
                end
                default:
                begin
                    fail      = 1'b1;
                    fail_code = ebml_hdr_pkg::ERR_TRUNCATED;
                end
            endcase
            if (phase_reg != ebml_hdr_pkg::PH_SKIP && !done && !fail && end_of_data)
            begin
                fail      = 1'b1;
                fail_code = ebml_hdr_pkg::ERR_TRUNCATED;
            end
        end
        known_nonzero = !ones_next && (acc_next != '0);
        done_overrun  = done && known_nonzero && end_of_data;
        if (done && known_nonzero && skip_cfg_reg)
        begin
            skip_rem_next = acc_next;
        end
        halted_next = halted_reg || fail || done_overrun;
    end

    always_comb
    begin
        phase_next = phase_reg;
        if (work && !fail)
        begin
            case (phase_reg)
                ebml_hdr_pkg::PH_ID_LEAD:
                begin
                    phase_next = (lead_len == 4'd1) ? ebml_hdr_pkg::PH_SIZE_LEAD
                                                    : ebml_hdr_pkg::PH_ID_MORE;
                end
                ebml_hdr_pkg::PH_ID_MORE:
                begin
                    if (bl_last)
                    begin
                        phase_next = ebml_hdr_pkg::PH_SIZE_LEAD;
                    end
                end
                ebml_hdr_pkg::PH_SIZE_LEAD,
                ebml_hdr_pkg::PH_SIZE_MORE:
                begin
                    if (done)
                    begin
                        phase_next = (known_nonzero && skip_cfg_reg) ? ebml_hdr_pkg::PH_SKIP
                                                                     : ebml_hdr_pkg::PH_ID_LEAD;
                    end
                    else
                    begin
                        phase_next = ebml_hdr_pkg::PH_SIZE_MORE;
                    end
                end
                ebml_hdr_pkg::PH_SKIP:
                begin
                    if (skip_end)
                    begin
                        phase_next = ebml_hdr_pkg::PH_ID_LEAD;
                    end
                end
                default:
                begin
                    phase_next = ebml_hdr_pkg::PH_ID_LEAD;
                end
            endcase
        end
    end

    always_comb
    begin
        res_valid = done || fail;
        if (fail)
        begin
            res                = '0;
            res.content_offset = pos_reg;
            res.error_code     = fail_code;
        end
        else
        begin
            res.element_id     = held_id_reg;
            res.id_length      = id_len_reg;
            res.content_size   = acc_next;
            res.size_length    = size_len_next;
            res.unknown_size   = ones_next;
            res.content_offset = pos_next;
            res.error_code     = done_overrun ? ebml_hdr_pkg::ERR_OVERRUN
                                              : ebml_hdr_pkg::ERR_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= ebml_hdr_pkg::PH_ID_LEAD;
            acc_reg      <= '0;
            bl_reg       <= '0;
            held_id_reg  <= '0;
            id_len_reg   <= '0;
            size_len_reg <= '0;
            ones_reg     <= 1'b0;
            skip_rem_reg <= '0;
            pos_reg      <= '0;
            halted_reg   <= 1'b0;
            skip_cfg_reg <= 1'b1;
        end
        else
        begin
            phase_reg    <= phase_next;
            acc_reg      <= acc_next;
            bl_reg       <= bl_next;
            held_id_reg  <= held_id_next;
            id_len_reg   <= id_len_next;
            size_len_reg <= size_len_next;
            ones_reg     <= ones_next;
            skip_rem_reg <= skip_rem_next;
            pos_reg      <= pos_next;
            halted_reg   <= halted_next;
            skip_cfg_reg <= skip_cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ebml_hdr_out_stage.sv =====
// ----------------------------------------------------------------------------
// EBML header parser output stage
// Holds one header result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ebml_hdr_out_stage (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    load,
    input  wire ebml_hdr_pkg::result_t   res,
    output logic                         space,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // element_id, id_length, content_size, size_length, unknown_size,
    // content_offset
    output logic [ebml_hdr_pkg::OUT_TDATA_W-1:0] m_tdata,
    // error_code
    output logic [ebml_hdr_pkg::OUT_TUSER_W-1:0] m_tuser
);

    logic                  valid_reg;
    logic                  valid_next;
    ebml_hdr_pkg::result_t res_reg;

    assign space = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {res_reg.content_offset, res_reg.unknown_size, res_reg.size_length,
                       res_reg.content_size, res_reg.id_length, res_reg.element_id};
    assign m_tuser  = res_reg.error_code;

endmodule

`default_nettype wire

// ===== rtl/ebml_element_header_parser_top.sv =====
// ----------------------------------------------------------------------------
// EBML element header parser
// Parses EBML element headers from a byte stream, one byte per cycle while the output has space.
// ----------------------------------------------------------------------------
// The input stream carries one byte per request in s_tdata, with s_tlast
// marking the last byte of the readable region. Every completed header, and
// every error, yields one request on the output stream: the header fields in
// m_tdata and the error code in m_tuser. Bytes that complete no header yield
// nothing. The cfg channel writes the skip_content bit and is always ready;
// it must be written only while the block is idle, a rule on the user that
// the block itself does not enforce. A byte is registered in the input stage
// on acceptance, then decoded and written into the output register when the
// output stage has space.
// Throughput is one byte per cycle while the output stage has space. A waiting
// result does not block the next byte from being registered; when the
// receiver stalls, the pipeline holds and s_tready falls once both
// registers are full.
// Reset clears both stages, sets skip_content to one and restarts the byte
// count at zero. After an error the block keeps taking bytes but reports
// nothing more until reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ebml_element_header_parser_top (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // data_byte
    input  wire logic         s_tlast,   // end_of_data
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // element_id, id_length, content_size, size_length, unknown_size,
    // content_offset
    output logic [143:0]      m_tdata,
    output logic [2:0]        m_tuser,   // error_code
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic         cfg_data   // skip_content
);

    logic                  byte_valid;
    logic [7:0]            data_byte;
    logic                  end_of_data;
    logic                  space;
    logic                  advance;
    logic                  res_valid;
    ebml_hdr_pkg::result_t res;

    assign advance = byte_valid && space;

    ebml_hdr_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .take        (advance),
        .byte_valid  (byte_valid),
        .data_byte   (data_byte),
        .end_of_data (end_of_data)
    );

    ebml_hdr_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .advance     (advance),
        .data_byte   (data_byte),
        .end_of_data (end_of_data),
        .res_valid   (res_valid),
        .res         (res)
    );

    ebml_hdr_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && res_valid),
        .res      (res),
        .space    (space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
